// ===== rtl/core/b64d_pkg.sv =====
// Shared types, codes and the character classifier of the Base64 stream decoder.
package b64d_pkg;

  // Character classes above the 0..63 sextet range
  localparam logic [6:0] CLS_LINEFEED = 7'd64;
  localparam logic [6:0] CLS_PAD      = 7'd65;
  localparam logic [6:0] CLS_INVALID  = 7'd66;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_DECODE = 2'd0,
    PHASE_PADDED = 2'd1,
    PHASE_ERROR  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_message;
  } char_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       kind;
    logic [15:0] byte_count;
    logic        last_of_run;
  } result_beat_t;

  // Work for the back end: up to three data bytes (first in the top byte)
  // followed by an optional status beat.
  typedef struct packed {
    logic [1:0]  nbytes;
    logic [23:0] bytes;
    logic        has_status;
    logic        status_err;
    logic [15:0] count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] v;
    v = CLS_INVALID;
    priority if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B) v = 7'd62;
    else if (c == 8'h2F) v = 7'd63;
    else if (c == 8'h0A) v = CLS_LINEFEED;
    else if (c == 8'h3D || c == 8'h00) v = CLS_PAD;
    else v = CLS_INVALID;
    return v;
  endfunction

endpackage

// ===== rtl/core/b64d_front.sv =====
// Front end: classifies characters, gathers sextets, checks capacity, issues commands.
module b64d_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_data,
  input  logic                    accept,
  input  b64d_pkg::char_beat_t    beat,
  output logic                    push,
  output b64d_pkg::cmd_t          cmd
);

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [CW:0] CAP = (CW+1)'((64'd1 << COUNT_BITS) - 64'd1);

  logic [15:0]            max_output_bytes;
  logic [17:0]            acc, acc_next;
  logic [1:0]             cnt, cnt_next;
  logic [COUNT_BITS-1:0]  emitted, emitted_next;
  b64d_pkg::phase_t       phase, phase_next;

  logic [6:0]  v;
  logic [23:0] grp;
  logic        is_sextet, grp_fire, grp_ok;
  logic [1:0]  tail_n;
  logic [CW:0] em_ext, max_ext, limit, sum3, sumt;
  logic        tail_ok;
  b64d_pkg::phase_t phase_a;
  logic [17:0] acc_a;
  logic [1:0]  cnt_a;
  logic [CW:0] em_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_bytes <= 16'hFFFF;
    end else if (cfg_we) begin
      max_output_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      cnt     <= '0;
      emitted <= '0;
      phase   <= b64d_pkg::PHASE_DECODE;
    end else if (accept) begin
      acc     <= acc_next;
      cnt     <= cnt_next;
      emitted <= emitted_next;
      phase   <= phase_next;
    end
  end

  always_comb begin
    v         = b64d_pkg::classify(beat.in_char);
    em_ext    = (CW+1)'(emitted);
    max_ext   = (CW+1)'(max_output_bytes);
    limit     = (max_ext < CAP) ? max_ext : CAP;
    sum3      = em_ext + (CW+1)'(3);
    grp       = {acc, v[5:0]};
    is_sextet = (phase == b64d_pkg::PHASE_DECODE) && (v < b64d_pkg::CLS_LINEFEED);
    grp_fire  = is_sextet && (cnt == 2'd3);
    grp_ok    = grp_fire && (sum3 <= limit);

    // after the character itself
    phase_a = phase;
    acc_a   = acc;
    cnt_a   = cnt;
    em_b    = em_ext;
    if (phase == b64d_pkg::PHASE_DECODE) begin
      if (v == b64d_pkg::CLS_INVALID) begin
        phase_a = b64d_pkg::PHASE_ERROR;
      end else if (v == b64d_pkg::CLS_PAD) begin
        phase_a = b64d_pkg::PHASE_PADDED;
      end else if (is_sextet) begin
        if (grp_fire) begin
          acc_a = '0;
          cnt_a = '0;
          if (grp_ok) begin
            em_b = sum3;
          end else begin
            phase_a = b64d_pkg::PHASE_ERROR;
          end
        end else begin
          acc_a = {acc[11:0], v[5:0]};
          cnt_a = cnt + 2'd1;
        end
      end
    end

    // end of message tail: three sextets give two bytes, two give one
    tail_n  = (cnt_a == 2'd3) ? 2'd2 : (cnt_a == 2'd2) ? 2'd1 : 2'd0;
    sumt    = em_ext + (CW+1)'(tail_n);
    tail_ok = (sumt <= limit);

    cmd            = '0;
    cmd.has_status = beat.end_of_message;
    if (grp_ok) begin
      cmd.nbytes = 2'd3;
      cmd.bytes  = grp;
    end
    phase_next = phase_a;
    if (beat.end_of_message && phase_a != b64d_pkg::PHASE_ERROR && tail_n != 2'd0) begin
      if (tail_ok) begin
        cmd.nbytes = tail_n;
        cmd.bytes  = (tail_n == 2'd2) ? {acc_a[17:10], acc_a[9:2], 8'h00}
                                      : {acc_a[11:4], 16'h0000};
        em_b       = sumt;
      end else begin
        phase_next = b64d_pkg::PHASE_ERROR;
      end
    end
    cmd.status_err = (phase_next == b64d_pkg::PHASE_ERROR);
    cmd.count      = cmd.status_err ? 16'h0000 : em_b[15:0];

    if (beat.end_of_message) begin
      acc_next     = '0;
      cnt_next     = '0;
      emitted_next = '0;
      phase_next   = b64d_pkg::PHASE_DECODE;
    end else begin
      acc_next     = acc_a;
      cnt_next     = cnt_a;
      emitted_next = em_b[COUNT_BITS-1:0];
    end

    push = accept && (cmd.nbytes != 2'd0 || cmd.has_status);
  end

endmodule

// ===== rtl/core/b64d_fifo.sv =====
// Short command queue between the front and back ends.
module b64d_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  b64d_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output b64d_pkg::cmd_t       head,
  output b64d_pkg::q_status_t  status
);

  b64d_pkg::cmd_t mem [b64d_pkg::QUEUE_DEPTH];
  logic [b64d_pkg::QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [b64d_pkg::QPTR_BITS:0]   fill;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (b64d_pkg::QPTR_BITS+1)'(push) - (b64d_pkg::QPTR_BITS+1)'(pop);
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = (fill == (b64d_pkg::QPTR_BITS+1)'(b64d_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);

endmodule

// ===== rtl/core/b64d_back.sv =====
// Back end: expands commands into output-register result beats, one per cycle unless stalled.
module b64d_back (
  input  logic                   clk,
  input  logic                   rst,
  input  b64d_pkg::cmd_t         head,
  input  b64d_pkg::q_status_t    qstat,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output b64d_pkg::result_beat_t result
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       load, last;
  b64d_pkg::result_beat_t beat_next;

  always_comb begin
    total = {1'b0, head.nbytes} + {2'b00, head.has_status};
    last  = ({1'b0, idx} == total - 3'd1);
    load  = !qstat.empty && (!result_valid || !result_stall);
    pop   = load && last;

    beat_next = '0;
    beat_next.last_of_run = last;
    if (idx < head.nbytes) begin
      beat_next.kind = b64d_pkg::KIND_DATA;
      unique case (idx)
        2'd0:    beat_next.out_byte = head.bytes[23:16];
        2'd1:    beat_next.out_byte = head.bytes[15:8];
        default: beat_next.out_byte = head.bytes[7:0];
      endcase
    end else if (head.status_err) begin
      beat_next.kind = b64d_pkg::KIND_ERROR;
    end else begin
      beat_next.kind       = b64d_pkg::KIND_OK;
      beat_next.byte_count = head.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
      idx          <= last ? 2'd0 : idx + 2'd1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= beat_next;
    end
  end

endmodule

// ===== rtl/core/base64_stream_decoder_unit.sv =====
// Base64 stream decoder: top level joining front end, command queue and back end.
//
// Takes one encoded character per beat on the char channel (end_of_message
// on the last one) and gives decoded bytes and one status beat per message on
// the result channel. A character is taken every cycle while the four-entry
// command queue has room; the front end classifies it, gathers sextets and
// checks the byte count against max_output_bytes in that same cycle. The back
// end sends one result beat per cycle from the queue while the result side
// does not stall, so a character that makes several results holds the back
// end for each (at most four: a full group plus status). Input only stalls
// when results on average outnumber characters, or the result side stalls,
// long enough to fill the queue. max_output_bytes may only be written
// between messages with the block drained. COUNT_BITS sets the width of the
// per-message byte counter and so a second cap on it.
module base64_stream_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_data,
  input  logic                   char_valid,
  output logic                   char_stall,
  input  b64d_pkg::char_beat_t   char_beat,
  output logic                   result_valid,
  input  logic                   result_stall,
  output b64d_pkg::result_beat_t result
);

  logic                accept, push, pop;
  b64d_pkg::cmd_t      cmd, head;
  b64d_pkg::q_status_t qstat;

  // stall from queue fill only, never from the result side directly
  assign char_stall = qstat.full;
  assign accept     = char_valid && !char_stall;

  b64d_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .beat     (char_beat),
    .push     (push),
    .cmd      (cmd)
  );

  b64d_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .status   (qstat)
  );

  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
